@@ src/mcim_pkg.sv @@
package mcim_pkg;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_WARNING = 2'd1;
	localparam logic [1:0] ST_FAULT   = 2'd2;

	localparam int LIMITS_W = 64;

	typedef struct packed {
		logic               op;
		logic [3:0]         channel_index;
		logic signed [15:0] sample;
		logic signed [15:0] warning_low;
		logic signed [15:0] warning_high;
		logic signed [15:0] fault_low;
		logic signed [15:0] fault_high;
	} item_t;

	typedef struct packed {
		logic       accepted;
		logic [3:0] channel;
		logic [1:0] status;
		logic [1:0] worst;
		logic       any_fault;
		logic       any_warning;
	} result_t;

	typedef struct packed {
		logic signed [15:0] warning_low;
		logic signed [15:0] warning_high;
		logic signed [15:0] fault_low;
		logic signed [15:0] fault_high;
	} limits_t;

	typedef struct packed {
		logic capture;
		logic read;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

@@ src/mcim_ram.sv @@
module mcim_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/mcim_ctrl.sv @@
module mcim_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  mcim_pkg::sts_t sts,
	output mcim_pkg::cmd_t cmd
);
	import mcim_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		READ,
		CALC
	} state_t;

	state_t state_q;
	logic   stall_q;

	assign item_stall  = stall_q;
	assign cmd.capture = item_valid && !stall_q;
	assign cmd.read    = (state_q == READ);
	assign cmd.commit  = (state_q == CALC) && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			stall_q <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (item_valid && !stall_q) begin
						state_q <= READ;
						stall_q <= 1'b1;
					end
				end
				READ: begin
					state_q <= CALC;
				end
				CALC: begin
					if (sts.out_free) begin
						state_q <= IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

@@ src/mcim_dp.sv @@
module mcim_dp #(
	parameter int CHANNELS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mcim_pkg::item_t   item,
	input  mcim_pkg::cmd_t    cmd,
	output mcim_pkg::sts_t    sts,
	output mcim_pkg::result_t result,
	output logic              result_valid,
	input  logic              result_stall
);
	import mcim_pkg::*;

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CW = $clog2(CHANNELS + 1);

	item_t   item_q;
	result_t result_q;
	logic    result_valid_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] fault_cnt_q;
	logic [CW-1:0] warn_cnt_q;

	logic [CW+3:0] idx_cmp;
	logic [CW+3:0] cnt_cmp;
	logic [AW+3:0] idx_wide;
	logic [AW+CW-1:0] cnt_wide;
	logic [AW-1:0] idx_addr;
	logic [AW-1:0] cnt_addr;
	logic [3:0]    cnt_chan;
	logic          is_add;
	logic          full;
	logic          add_ok;
	logic          eval_ok;
	logic [LIMITS_W-1:0] lim_rdata;
	logic [1:0]    old_st;
	logic [1:0]    new_st;
	limits_t       lim;
	logic          inc_f;
	logic          dec_f;
	logic          inc_w;
	logic          dec_w;
	logic [CW-1:0] fault_nx;
	logic [CW-1:0] warn_nx;
	logic [1:0]    worst_nx;
	result_t       result_nx;
	limits_t       lim_wdata;

	assign idx_cmp  = {{CW{1'b0}}, item_q.channel_index};
	assign cnt_cmp  = {4'b0000, count_q};
	assign idx_wide = {{AW{1'b0}}, item_q.channel_index};
	assign cnt_wide = {{AW{1'b0}}, count_q};
	assign idx_addr = idx_wide[AW-1:0];
	assign cnt_addr = cnt_wide[AW-1:0];
	assign cnt_chan = cnt_cmp[3:0];

	assign is_add  = (item_q.op == OP_ADD);
	assign full    = (count_q == CW'(CHANNELS));
	assign add_ok  = is_add && !full;
	assign eval_ok = !is_add && (idx_cmp < cnt_cmp);

	assign lim = limits_t'(lim_rdata);

	always_comb begin
		if (item_q.sample <= lim.fault_low || item_q.sample >= lim.fault_high) begin
			new_st = ST_FAULT;
		end else if (item_q.sample <= lim.warning_low ||
				item_q.sample >= lim.warning_high) begin
			new_st = ST_WARNING;
		end else begin
			new_st = ST_OK;
		end
	end

	assign inc_f = eval_ok && (new_st == ST_FAULT);
	assign dec_f = eval_ok && (old_st == ST_FAULT);
	assign inc_w = eval_ok && (new_st == ST_WARNING);
	assign dec_w = eval_ok && (old_st == ST_WARNING);

	assign fault_nx = fault_cnt_q + CW'(inc_f) - CW'(dec_f);
	assign warn_nx  = warn_cnt_q + CW'(inc_w) - CW'(dec_w);

	always_comb begin
		if (fault_nx != '0) begin
			worst_nx = ST_FAULT;
		end else if (warn_nx != '0) begin
			worst_nx = ST_WARNING;
		end else begin
			worst_nx = ST_OK;
		end
	end

	always_comb begin
		result_nx             = '0;
		result_nx.worst       = worst_nx;
		result_nx.any_fault   = (worst_nx == ST_FAULT);
		result_nx.any_warning = (worst_nx != ST_OK);
		if (is_add) begin
			result_nx.accepted = add_ok;
			result_nx.channel  = add_ok ? cnt_chan : 4'd0;
			result_nx.status   = ST_OK;
		end else begin
			result_nx.accepted = eval_ok;
			result_nx.channel  = item_q.channel_index;
			result_nx.status   = eval_ok ? new_st : ST_FAULT;
		end
	end

	always_comb begin
		lim_wdata.warning_low  = item_q.warning_low;
		lim_wdata.warning_high = item_q.warning_high;
		lim_wdata.fault_low    = item_q.fault_low;
		lim_wdata.fault_high   = item_q.fault_high;
	end

	mcim_ram #(
		.WIDTH(LIMITS_W),
		.DEPTH(CHANNELS)
	) u_limit_ram (
		.clk  (clk),
		.we   (cmd.commit && add_ok),
		.waddr(cnt_addr),
		.wdata(lim_wdata),
		.re   (cmd.read),
		.raddr(idx_addr),
		.rdata(lim_rdata)
	);

	mcim_ram #(
		.WIDTH(2),
		.DEPTH(CHANNELS)
	) u_status_ram (
		.clk  (clk),
		.we   (cmd.commit && (add_ok || eval_ok)),
		.waddr(is_add ? cnt_addr : idx_addr),
		.wdata(is_add ? ST_OK : new_st),
		.re   (cmd.read),
		.raddr(idx_addr),
		.rdata(old_st)
	);

	assign sts.out_free = !result_valid_q || !result_stall;
	assign result       = result_q;
	assign result_valid = result_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.commit) begin
			result_q <= result_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			fault_cnt_q    <= '0;
			warn_cnt_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				fault_cnt_q    <= fault_nx;
				warn_cnt_q     <= warn_nx;
				result_valid_q <= 1'b1;
				if (add_ok) begin
					count_q <= count_q + CW'(1);
				end
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ src/multi_channel_interlock_monitor.sv @@
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_stall     mcim_pkg::item_t
// result    out        result_valid / result_stall mcim_pkg::result_t
//
// Each item passes through capture, limit and status memory read, and evaluate and commit,
// with item_stall high until commit; the limit and status memory read is registered.
// Reset clears the channel count and the fault and warning counters; no clearing pass.
// A stalled result holds in the output register; the commit waits until it is free.
module multi_channel_interlock_monitor #(
	parameter int CHANNELS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  mcim_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output mcim_pkg::result_t result
);
	import mcim_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mcim_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mcim_dp #(
		.CHANNELS(CHANNELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.sts         (sts),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

endmodule
